// ----- hw/rtl/jsu_pkg.sv -----
`timescale 1ns / 1ps

package jsu_pkg;

  // Result status codes.
  localparam logic [3:0] ST_DATA        = 4'd0;
  localparam logic [3:0] ST_CLOSED      = 4'd1;
  localparam logic [3:0] ST_CTRL_CHAR   = 4'd2;
  localparam logic [3:0] ST_TRUNC_ESC   = 4'd3;
  localparam logic [3:0] ST_BAD_ESC     = 4'd4;
  localparam logic [3:0] ST_TRUNC_UNI   = 4'd5;
  localparam logic [3:0] ST_BAD_HEX     = 4'd6;
  localparam logic [3:0] ST_UNPAIR_HIGH = 4'd7;
  localparam logic [3:0] ST_UNPAIR_LOW  = 4'd8;
  localparam logic [3:0] ST_UNTERM      = 4'd9;

  // Characters of interest.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [15:0] HI_SURR_LO = 16'hd800;
  localparam logic [15:0] HI_SURR_HI = 16'hdbff;
  localparam logic [15:0] LO_SURR_LO = 16'hdc00;
  localparam logic [15:0] LO_SURR_HI = 16'hdfff;

  typedef enum logic [5:0] {
    MODE_PLAIN = 6'b000001,
    MODE_ESC   = 6'b000010,
    MODE_HIQ   = 6'b000100,
    MODE_EXPB  = 6'b001000,
    MODE_EXPU  = 6'b010000,
    MODE_LOQ   = 6'b100000
  } mode_t;

  // All results caused by one input beat: data bytes first, then an
  // optional status result.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      nbytes;
    logic            has_stat;
    logic [3:0]      stat;
  } bundle_t;

  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      nbytes;
  } utf8_t;

  // Returns {non_hex, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'b1_0000;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b0, b[3:0]};
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b0, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp <= 21'h7f) begin
      r.data[0] = cp[7:0];
      r.nbytes  = 3'd1;
    end else if (cp <= 21'h7ff) begin
      r.data[0] = {3'b110, cp[10:6]};
      r.data[1] = {2'b10, cp[5:0]};
      r.nbytes  = 3'd2;
    end else if (cp <= 21'hffff) begin
      r.data[0] = {4'b1110, cp[15:12]};
      r.data[1] = {2'b10, cp[11:6]};
      r.data[2] = {2'b10, cp[5:0]};
      r.nbytes  = 3'd3;
    end else begin
      r.data[0] = {5'b11110, cp[20:18]};
      r.data[1] = {2'b10, cp[17:12]};
      r.data[2] = {2'b10, cp[11:6]};
      r.data[3] = {2'b10, cp[5:0]};
      r.nbytes  = 3'd4;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/json_string_unescape_utf8_core.sv -----
`timescale 1ns / 1ps
// The first result of a beat passes the input register and then the result
// register before it is presented. One input beat per cycle while each byte
// yields at most one result and the receiver does not stall; a byte with
// several results holds the result register until its last result is taken.
// The result register serializes bundles of up to five results.
// Reset (rst_n low, synchronous) empties both stages and returns the
// decoder to plain string content.
module json_string_unescape_utf8_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_buffer,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [3:0] out_status,
  output logic       out_last_of_run
);

  // Input register stage. A beat moves on into the decoder whenever the
  // result register is empty or drains its last result in the same cycle,
  // so input flows at one beat per cycle while each byte yields at most one
  // result and the receiver does not stall. A waiting result holds the beat.
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_eob_r;
  logic       accept;
  logic       step;
  logic       res_free;
  logic       load;

  jsu_pkg::bundle_t bundle;

  assign step     = in_vld_r && res_free;
  assign in_ready = !in_vld_r || step;
  assign accept   = in_valid && in_ready;

  // Bytes that yield nothing (a backslash, hex digits) only update the
  // decoder state and leave the result register untouched.
  assign load = step && (bundle.nbytes != 3'd0 || bundle.has_stat);

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (step) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_byte;
      in_eob_r  <= in_end_of_buffer;
    end
  end

  // Escape, hex and surrogate decoding with the string state.
  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (in_byte_r),
    .eob     (in_eob_r),
    .bundle  (bundle)
  );

  // Result register and output sequencing.
  jsu_serial u_serial (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .bundle          (bundle),
    .free            (res_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ----- hw/rtl/jsu_decode.sv -----
`timescale 1ns / 1ps

// Escape and surrogate decoder. Holds the string state and turns one byte
// into the bundle of results it causes; state advances on step.
module jsu_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        byte_in,
  input  logic              eob,
  output jsu_pkg::bundle_t  bundle
);

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [9:0]  hh_r, hh_nxt;
  logic        bad_r, bad_nxt;

  logic [4:0]  hex;
  logic [15:0] acc_new;
  logic        bad_new;
  logic        fin;
  logic [20:0] pair_cp;
  jsu_pkg::utf8_t enc;
  jsu_pkg::bundle_t bnd;

  assign hex     = jsu_pkg::hex_digit(byte_in);
  assign acc_new = {acc_r[11:0], hex[3:0]};
  assign bad_new = bad_r | hex[4];
  assign pair_cp = 21'h10000 + {1'b0, hh_r, acc_new[9:0]};

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    hh_nxt   = hh_r;
    bad_nxt  = bad_r;
    fin      = 1'b0;
    bnd      = '0;
    enc      = '0;
    case (mode_r)
      jsu_pkg::MODE_ESC: begin
        mode_nxt = jsu_pkg::MODE_PLAIN;
        bnd.nbytes = 3'd1;
        case (byte_in)
          jsu_pkg::CH_QUOTE:  bnd.data[0] = jsu_pkg::CH_QUOTE;
          jsu_pkg::CH_BSLASH: bnd.data[0] = jsu_pkg::CH_BSLASH;
          jsu_pkg::CH_SLASH:  bnd.data[0] = jsu_pkg::CH_SLASH;
          jsu_pkg::CH_B:      bnd.data[0] = 8'h08;
          jsu_pkg::CH_F:      bnd.data[0] = 8'h0c;
          jsu_pkg::CH_N:      bnd.data[0] = 8'h0a;
          jsu_pkg::CH_R:      bnd.data[0] = 8'h0d;
          jsu_pkg::CH_T:      bnd.data[0] = 8'h09;
          jsu_pkg::CH_U: begin
            bnd.nbytes = 3'd0;
            mode_nxt   = jsu_pkg::MODE_HIQ;
            cnt_nxt    = 2'd0;
            acc_nxt    = 16'd0;
            bad_nxt    = 1'b0;
            if (eob) begin
              bnd.has_stat = 1'b1;
              bnd.stat     = jsu_pkg::ST_TRUNC_UNI;
              fin          = 1'b1;
            end
          end
          default: begin
            bnd.nbytes   = 3'd0;
            bnd.has_stat = 1'b1;
            bnd.stat     = jsu_pkg::ST_BAD_ESC;
            fin          = 1'b1;
          end
        endcase
      end
      jsu_pkg::MODE_HIQ: begin
        acc_nxt = acc_new;
        bad_nxt = bad_new;
        if (cnt_r == 2'd3) begin
          if (bad_new) begin
            bnd.has_stat = 1'b1;
            bnd.stat     = jsu_pkg::ST_BAD_HEX;
            fin          = 1'b1;
          end else if (acc_new >= jsu_pkg::HI_SURR_LO && acc_new <= jsu_pkg::HI_SURR_HI) begin
            if (eob) begin
              bnd.has_stat = 1'b1;
              bnd.stat     = jsu_pkg::ST_UNPAIR_HIGH;
              fin          = 1'b1;
            end else begin
              hh_nxt   = acc_new[9:0];
              mode_nxt = jsu_pkg::MODE_EXPB;
            end
          end else if (acc_new >= jsu_pkg::LO_SURR_LO && acc_new <= jsu_pkg::LO_SURR_HI) begin
            bnd.has_stat = 1'b1;
            bnd.stat     = jsu_pkg::ST_UNPAIR_LOW;
            fin          = 1'b1;
          end else begin
            enc        = jsu_pkg::utf8_encode({5'd0, acc_new});
            bnd.data   = enc.data;
            bnd.nbytes = enc.nbytes;
            mode_nxt   = jsu_pkg::MODE_PLAIN;
          end
        end else begin
          cnt_nxt = cnt_r + 2'd1;
          if (eob) begin
            bnd.has_stat = 1'b1;
            bnd.stat     = jsu_pkg::ST_TRUNC_UNI;
            fin          = 1'b1;
          end
        end
      end
      jsu_pkg::MODE_EXPB: begin
        if (byte_in != jsu_pkg::CH_BSLASH || eob) begin
          bnd.has_stat = 1'b1;
          bnd.stat     = jsu_pkg::ST_UNPAIR_HIGH;
          fin          = 1'b1;
        end else begin
          mode_nxt = jsu_pkg::MODE_EXPU;
        end
      end
      jsu_pkg::MODE_EXPU: begin
        if (byte_in != jsu_pkg::CH_U || eob) begin
          bnd.has_stat = 1'b1;
          bnd.stat     = jsu_pkg::ST_UNPAIR_HIGH;
          fin          = 1'b1;
        end else begin
          mode_nxt = jsu_pkg::MODE_LOQ;
          cnt_nxt  = 2'd0;
          acc_nxt  = 16'd0;
          bad_nxt  = 1'b0;
        end
      end
      jsu_pkg::MODE_LOQ: begin
        acc_nxt = acc_new;
        bad_nxt = bad_new;
        if (cnt_r == 2'd3) begin
          if (bad_new) begin
            bnd.has_stat = 1'b1;
            bnd.stat     = jsu_pkg::ST_BAD_HEX;
            fin          = 1'b1;
          end else if (acc_new < jsu_pkg::LO_SURR_LO || acc_new > jsu_pkg::LO_SURR_HI) begin
            bnd.has_stat = 1'b1;
            bnd.stat     = jsu_pkg::ST_UNPAIR_HIGH;
            fin          = 1'b1;
          end else begin
            enc        = jsu_pkg::utf8_encode(pair_cp);
            bnd.data   = enc.data;
            bnd.nbytes = enc.nbytes;
            mode_nxt   = jsu_pkg::MODE_PLAIN;
          end
        end else begin
          cnt_nxt = cnt_r + 2'd1;
          if (eob) begin
            bnd.has_stat = 1'b1;
            bnd.stat     = jsu_pkg::ST_UNPAIR_HIGH;
            fin          = 1'b1;
          end
        end
      end
      default: begin
        if (byte_in == jsu_pkg::CH_QUOTE) begin
          bnd.has_stat = 1'b1;
          bnd.stat     = jsu_pkg::ST_CLOSED;
          fin          = 1'b1;
        end else if (byte_in < jsu_pkg::CH_SPACE) begin
          bnd.has_stat = 1'b1;
          bnd.stat     = jsu_pkg::ST_CTRL_CHAR;
          fin          = 1'b1;
        end else if (byte_in == jsu_pkg::CH_BSLASH) begin
          if (eob) begin
            bnd.has_stat = 1'b1;
            bnd.stat     = jsu_pkg::ST_TRUNC_ESC;
            fin          = 1'b1;
          end else begin
            mode_nxt = jsu_pkg::MODE_ESC;
          end
        end else begin
          bnd.data[0] = byte_in;
          bnd.nbytes  = 3'd1;
        end
      end
    endcase

    // A string still open at the end of the buffer is reported after any
    // data this byte produced.
    if (eob && !fin) begin
      bnd.has_stat = 1'b1;
      bnd.stat     = jsu_pkg::ST_UNTERM;
    end
    if (eob || fin) begin
      mode_nxt = jsu_pkg::MODE_PLAIN;
      cnt_nxt  = 2'd0;
      acc_nxt  = 16'd0;
      hh_nxt   = 10'd0;
      bad_nxt  = 1'b0;
    end
  end

  assign bundle = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsu_pkg::MODE_PLAIN;
      cnt_r  <= 2'd0;
      acc_r  <= 16'd0;
      hh_r   <= 10'd0;
      bad_r  <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      hh_r   <= hh_nxt;
      bad_r  <= bad_nxt;
    end
  end

endmodule

// ----- hw/rtl/jsu_serial.sv -----
`timescale 1ns / 1ps

// Result register. Holds one bundle and hands its results out one beat
// at a time.
module jsu_serial (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  jsu_pkg::bundle_t  bundle,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic [3:0]        out_status,
  output logic              out_last_of_run
);

  jsu_pkg::bundle_t bnd_r;
  logic             vld_r, vld_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic [2:0]       total;
  logic             is_data;
  logic             last;
  logic             fire;
  logic             pop;

  assign total   = bnd_r.nbytes + {2'd0, bnd_r.has_stat};
  assign is_data = idx_r < bnd_r.nbytes;
  assign last    = idx_r == (total - 3'd1);
  assign fire    = vld_r && out_ready;
  assign pop     = fire && last;
  assign free    = !vld_r || pop;

  assign out_valid       = vld_r;
  assign out_byte        = is_data ? bnd_r.data[idx_r[1:0]] : 8'd0;
  assign out_status      = is_data ? jsu_pkg::ST_DATA : bnd_r.stat;
  assign out_last_of_run = last;

  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = 3'd0;
    end else if (pop) begin
      vld_nxt = 1'b0;
      idx_nxt = 3'd0;
    end else if (fire) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 3'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bnd_r <= bundle;
    end
  end

endmodule

// ----- sim/tb_json_string_unescape_utf8_core.sv -----
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8_core;

  // Cycles with no beat on either channel before the run is declared hung.
  // A result waits out the receiver's stalls, drawn anew every cycle, so even
  // the heaviest stall phase stays far below this.
  localparam int STALL_LIMIT = 1000;
  // Cycles waited after the last expected result is taken, so that a surplus
  // result from the core is still caught.
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BEATS = 394;

  // One stimulus beat. Rows marked typed carry their single expected
  // result in xb/xst; all other rows are checked against the predictor.
  typedef struct packed {
    logic [7:0] b;
    logic       eob;
    logic       typed;
    logic [7:0] xb;
    logic [3:0] xst;
  } stim_t;

  typedef struct packed {
    logic [7:0] b;
    logic [3:0] st;
    logic       last;
  } result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_buffer = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [3:0] out_status;
  logic       out_last_of_run;

  json_string_unescape_utf8_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_status       (out_status),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the decoder state, advanced once per accepted beat.
  jsu_pkg::mode_t dec_mode;
  logic [1:0]  ndigits;
  logic [15:0] quad_val;
  logic [9:0]  hi_bits;
  logic        quad_bad;

  result_t byte_results_q[$];  // results of the beat being decoded
  result_t decoded_q[$];       // results still owed by the core
  stim_t   stim_q[$];
  stim_t   directed_tbl [26];
  logic [7:0] text_q[$];       // string body under construction

  int mismatches = 0;
  int idle_cycles = 0;
  int send_pct = 0;
  int recv_pct = 0;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Returns {not_hex, value} for one character of a \u quad.
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h61 + 8'd10)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 8'd10)};
    return 5'b1_0000;
  endfunction

  task automatic clear_decoder();
    dec_mode = jsu_pkg::MODE_PLAIN;
    ndigits  = 2'd0;
    quad_val = 16'h0000;
    hi_bits  = 10'd0;
    quad_bad = 1'b0;
  endtask

  task automatic open_quad(input jsu_pkg::mode_t m);
    dec_mode = m;
    ndigits  = 2'd0;
    quad_val = 16'h0000;
    quad_bad = 1'b0;
  endtask

  task automatic emit(input logic [7:0] b, input logic [3:0] st);
    byte_results_q.insert(byte_results_q.size(), {b, st, 1'b0});
  endtask

  // A non-hex character still shifts in a zero nibble; it only poisons
  // the quad, which is reported once the fourth character arrives.
  task automatic shift_digit(input logic [7:0] c);
    logic [4:0] nib;
    nib = nibble_of(c);
    if (nib[4]) quad_bad = 1'b1;
    quad_val = {quad_val[11:0], nib[3:0]};
  endtask

  task automatic emit_utf8(input logic [20:0] cp);
    if (cp <= 21'h7f) begin
      emit(cp[7:0], jsu_pkg::ST_DATA);
    end else if (cp <= 21'h7ff) begin
      emit(8'hc0 | 8'(cp >> 6), jsu_pkg::ST_DATA);
      emit(8'h80 | 8'(cp & 21'h3f), jsu_pkg::ST_DATA);
    end else if (cp <= 21'hffff) begin
      emit(8'he0 | 8'(cp >> 12), jsu_pkg::ST_DATA);
      emit(8'h80 | 8'((cp >> 6) & 21'h3f), jsu_pkg::ST_DATA);
      emit(8'h80 | 8'(cp & 21'h3f), jsu_pkg::ST_DATA);
    end else begin
      emit(8'hf0 | 8'(cp >> 18), jsu_pkg::ST_DATA);
      emit(8'h80 | 8'((cp >> 12) & 21'h3f), jsu_pkg::ST_DATA);
      emit(8'h80 | 8'((cp >> 6) & 21'h3f), jsu_pkg::ST_DATA);
      emit(8'h80 | 8'(cp & 21'h3f), jsu_pkg::ST_DATA);
    end
  endtask

  // Works out every result one input beat causes, in order, with the
  // final one flagged as last of its run.
  task automatic decode_byte(input logic [7:0] c, input logic eob);
    logic done;
    done = 1'b0;
    byte_results_q.delete();
    case (dec_mode)
      jsu_pkg::MODE_ESC: begin
        dec_mode = jsu_pkg::MODE_PLAIN;
        case (c)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
            emit(c, jsu_pkg::ST_DATA);
          jsu_pkg::CH_B: emit(8'h08, jsu_pkg::ST_DATA);
          jsu_pkg::CH_F: emit(8'h0c, jsu_pkg::ST_DATA);
          jsu_pkg::CH_N: emit(8'h0a, jsu_pkg::ST_DATA);
          jsu_pkg::CH_R: emit(8'h0d, jsu_pkg::ST_DATA);
          jsu_pkg::CH_T: emit(8'h09, jsu_pkg::ST_DATA);
          jsu_pkg::CH_U: begin
            open_quad(jsu_pkg::MODE_HIQ);
            if (eob) begin
              emit(8'h00, jsu_pkg::ST_TRUNC_UNI);
              done = 1'b1;
            end
          end
          default: begin
            emit(8'h00, jsu_pkg::ST_BAD_ESC);
            done = 1'b1;
          end
        endcase
      end
      jsu_pkg::MODE_HIQ: begin
        shift_digit(c);
        if (ndigits == 2'd3) begin
          if (quad_bad) begin
            emit(8'h00, jsu_pkg::ST_BAD_HEX);
            done = 1'b1;
          end else if (quad_val >= jsu_pkg::HI_SURR_LO &&
                       quad_val <= jsu_pkg::HI_SURR_HI) begin
            // A high half at the very end cannot be paired any more.
            if (eob) begin
              emit(8'h00, jsu_pkg::ST_UNPAIR_HIGH);
              done = 1'b1;
            end else begin
              hi_bits  = quad_val[9:0];
              dec_mode = jsu_pkg::MODE_EXPB;
            end
          end else if (quad_val >= jsu_pkg::LO_SURR_LO &&
                       quad_val <= jsu_pkg::LO_SURR_HI) begin
            emit(8'h00, jsu_pkg::ST_UNPAIR_LOW);
            done = 1'b1;
          end else begin
            emit_utf8({5'd0, quad_val});
            dec_mode = jsu_pkg::MODE_PLAIN;
          end
        end else begin
          ndigits++;
          if (eob) begin
            emit(8'h00, jsu_pkg::ST_TRUNC_UNI);
            done = 1'b1;
          end
        end
      end
      jsu_pkg::MODE_EXPB: begin
        if (c != jsu_pkg::CH_BSLASH || eob) begin
          emit(8'h00, jsu_pkg::ST_UNPAIR_HIGH);
          done = 1'b1;
        end else begin
          dec_mode = jsu_pkg::MODE_EXPU;
        end
      end
      jsu_pkg::MODE_EXPU: begin
        if (c != jsu_pkg::CH_U || eob) begin
          emit(8'h00, jsu_pkg::ST_UNPAIR_HIGH);
          done = 1'b1;
        end else begin
          open_quad(jsu_pkg::MODE_LOQ);
        end
      end
      jsu_pkg::MODE_LOQ: begin
        shift_digit(c);
        if (ndigits == 2'd3) begin
          if (quad_bad) begin
            emit(8'h00, jsu_pkg::ST_BAD_HEX);
            done = 1'b1;
          end else if (quad_val < jsu_pkg::LO_SURR_LO ||
                       quad_val > jsu_pkg::LO_SURR_HI) begin
            emit(8'h00, jsu_pkg::ST_UNPAIR_HIGH);
            done = 1'b1;
          end else begin
            emit_utf8(21'h10000 + {1'b0, hi_bits, quad_val[9:0]});
            dec_mode = jsu_pkg::MODE_PLAIN;
          end
        end else begin
          // The low quad cut short counts against the high half.
          ndigits++;
          if (eob) begin
            emit(8'h00, jsu_pkg::ST_UNPAIR_HIGH);
            done = 1'b1;
          end
        end
      end
      default: begin
        if (c == jsu_pkg::CH_QUOTE) begin
          emit(8'h00, jsu_pkg::ST_CLOSED);
          done = 1'b1;
        end else if (c < jsu_pkg::CH_SPACE) begin
          emit(8'h00, jsu_pkg::ST_CTRL_CHAR);
          done = 1'b1;
        end else if (c == jsu_pkg::CH_BSLASH) begin
          if (eob) begin
            emit(8'h00, jsu_pkg::ST_TRUNC_ESC);
            done = 1'b1;
          end else begin
            dec_mode = jsu_pkg::MODE_ESC;
          end
        end else begin
          emit(c, jsu_pkg::ST_DATA);
        end
      end
    endcase
    // The buffer ran out inside a string that is still open.
    if (eob && !done) emit(8'h00, jsu_pkg::ST_UNTERM);
    if (eob || done) clear_decoder();
    if (byte_results_q.size() > 0) begin
      byte_results_q[byte_results_q.size() - 1].last = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------
  // Random string bodies
  // ---------------------------------------------------------------------

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  // Printable text; quote and backslash are kept for their own tokens.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h20, 8'hff));
    if (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSLASH) c = 8'h61;
    return c;
  endfunction

  function automatic logic [7:0] esc_char();
    case ($urandom_range(7))
      0: return jsu_pkg::CH_QUOTE;
      1: return jsu_pkg::CH_BSLASH;
      2: return jsu_pkg::CH_SLASH;
      3: return jsu_pkg::CH_B;
      4: return jsu_pkg::CH_F;
      5: return jsu_pkg::CH_N;
      6: return jsu_pkg::CH_R;
      default: return jsu_pkg::CH_T;
    endcase
  endfunction

  // Code points outside the surrogate block, of one to three UTF-8 bytes.
  function automatic logic [15:0] bmp_value();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'h0000, 16'h007f));
      1: return 16'($urandom_range(16'h0080, 16'h07ff));
      2: return 16'($urandom_range(16'h0800, 16'hd7ff));
      default: return 16'($urandom_range(16'he000, 16'hffff));
    endcase
  endfunction

  task automatic add_text(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endtask

  task automatic add_stim(input logic [7:0] b, input logic eob);
    stim_q.insert(stim_q.size(), {b, eob, 1'b0, 8'h00, jsu_pkg::ST_DATA});
  endtask

  task automatic add_uesc(input logic [15:0] v);
    add_text(jsu_pkg::CH_BSLASH);
    add_text(jsu_pkg::CH_U);
    add_text(hex_char(v[15:12]));
    add_text(hex_char(v[11:8]));
    add_text(hex_char(v[7:4]));
    add_text(hex_char(v[3:0]));
  endtask

  // Builds one string body of a few tokens, mostly well formed, then ends
  // it with a quote, cuts it off at the end of the buffer, or runs it into
  // a stray byte.
  task automatic gen_string();
    int          pick;
    int          cut;
    logic [7:0]  junk;
    logic [4:0]  nib;
    logic [15:0] hi;
    text_q.delete();
    repeat ($urandom_range(1, 6)) begin
      hi = jsu_pkg::HI_SURR_LO | 16'($urandom_range(0, 1023));
      case ($urandom_range(15))
        0, 1, 2, 3, 4: add_text(plain_char());
        5, 6: begin
          add_text(jsu_pkg::CH_BSLASH);
          add_text(esc_char());
        end
        7, 8: add_uesc(bmp_value());
        9, 10: begin
          add_uesc(hi);
          add_uesc(jsu_pkg::LO_SURR_LO | 16'($urandom_range(0, 1023)));
        end
        11: add_uesc(jsu_pkg::LO_SURR_LO | 16'($urandom_range(0, 1023)));
        12: begin
          // High half followed by something other than a full \u.
          add_uesc(hi);
          if ($urandom_range(1)) begin
            add_text(plain_char());
          end else begin
            add_text(jsu_pkg::CH_BSLASH);
            add_text(esc_char());
          end
        end
        13: begin
          add_uesc(hi);
          add_uesc(bmp_value());
        end
        14: begin
          // One character of the quad replaced by a non-hex byte, which
          // may be a control byte, a quote or a backslash.
          if ($urandom_range(1)) add_uesc(bmp_value());
          else add_uesc(hi);
          do begin
            junk = 8'($urandom_range(255));
            nib  = nibble_of(junk);
          end while (!nib[4]);
          text_q[text_q.size() - 1 - $urandom_range(3)] = junk;
        end
        default: begin
          if ($urandom_range(1)) begin
            add_text(jsu_pkg::CH_BSLASH);
            add_text(8'($urandom_range(255)));
          end else begin
            add_text(8'($urandom_range(0, 31)));
          end
        end
      endcase
    end
    pick = $urandom_range(99);
    if (pick < 70) begin
      foreach (text_q[i]) add_stim(text_q[i], 1'b0);
      add_stim(jsu_pkg::CH_QUOTE, ($urandom_range(9) == 0));
    end else if (pick < 88) begin
      // Cut anywhere, often in the middle of an escape or a quad.
      cut = $urandom_range(1, text_q.size());
      for (int i = 0; i < cut; i++) begin
        add_stim(text_q[i], (i == cut - 1));
      end
    end else begin
      foreach (text_q[i]) add_stim(text_q[i], 1'b0);
      add_stim(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side: random backpressure and the in-order check.
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $error("result with nothing pending: out_byte %0h out_status %0d",
               out_byte, out_status);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.b) begin
          $error("out_byte: expected %0h, got %0h", want.b, out_byte);
          mismatches++;
        end
        if (out_status !== want.st) begin
          $error("out_status: expected %0d, got %0d", want.st, out_status);
          mismatches++;
        end
        if (out_last_of_run !== want.last) begin
          $error("out_last_of_run: expected %0b, got %0b", want.last,
                 out_last_of_run);
          mismatches++;
        end
      end
    end
  end

  // Hang detection: any beat on either channel restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  initial begin
    stim_t s;
    int    phase;

    // Directed rows. Errors and a few single bytes after reset are typed
    // in; escapes and \u decoding are left to the predictor.
    directed_tbl = '{
      '{8'h41, 1'b0, 1'b1, 8'h41, jsu_pkg::ST_DATA},       // 'A' right after reset
      '{8'hff, 1'b0, 1'b1, 8'hff, jsu_pkg::ST_DATA},       // top byte passes through
      '{8'h00, 1'b0, 1'b1, 8'h00, jsu_pkg::ST_CTRL_CHAR},  // NUL is a control char
      '{jsu_pkg::CH_QUOTE, 1'b0, 1'b1, 8'h00, jsu_pkg::ST_CLOSED},  // empty string
      '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{jsu_pkg::CH_SLASH, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},   // escaped solidus
      '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h78, 1'b0, 1'b1, 8'h00, jsu_pkg::ST_BAD_ESC},    // backslash-x
      '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{jsu_pkg::CH_U, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h30, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h30, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h65, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h39, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},       // U+00E9, two bytes
      // Backslash at the end of the buffer.
      '{jsu_pkg::CH_BSLASH, 1'b1, 1'b1, 8'h00, jsu_pkg::ST_TRUNC_ESC},
      '{8'h5a, 1'b1, 1'b0, 8'h00, jsu_pkg::ST_DATA},       // data, then unterminated
      '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{jsu_pkg::CH_U, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h44, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h43, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h30, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h30, 1'b0, 1'b1, 8'h00, jsu_pkg::ST_UNPAIR_LOW}, // lone low surrogate
      '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{jsu_pkg::CH_U, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h31, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h32, 1'b1, 1'b1, 8'h00, jsu_pkg::ST_TRUNC_UNI}   // quad cut by the end
    };
    foreach (directed_tbl[i]) stim_q.insert(stim_q.size(), directed_tbl[i]);
    while (stim_q.size() < $size(directed_tbl) + RANDOM_BEATS) gen_string();

    clear_decoder();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_q[i]) begin
      s = stim_q[i];
      // Three equal phases: sender lean and receiver heavy on stalls, then
      // the reverse, then both running flat out.
      phase = (i * 3) / stim_q.size();
      send_pct = (phase == 0) ? 28 : (phase == 1) ? 65 : 0;
      recv_pct = (phase == 0) ? 65 : (phase == 1) ? 28 : 0;
      if ($urandom_range(99) < send_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while ($urandom_range(99) < send_pct) @(posedge clk);
      end
      in_valid         <= 1'b1;
      in_byte          <= s.b;
      in_end_of_buffer <= s.eob;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      // The beat went in at this edge; the decoder state moves on even
      // for typed rows, whose listed result replaces the predicted one.
      decode_byte(s.b, s.eob);
      if (s.typed) begin
        byte_results_q.delete();
        byte_results_q.insert(0, {s.xb, s.xst, 1'b1});
      end
      foreach (byte_results_q[k]) decoded_q.insert(decoded_q.size(), byte_results_q[k]);
    end
    in_valid <= 1'b0;
    recv_pct = 0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- json_string_unescape_utf8_core.f -----
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_decode.sv
hw/rtl/jsu_serial.sv
hw/rtl/json_string_unescape_utf8_core.sv
sim/tb_json_string_unescape_utf8_core.sv
